@@ rtl/sh2bp_pkg.sv @@
// Package for the sensor hit to body polar converter.
// Holds field widths, fixed-point constants, the CORDIC pipeline item type
// and the arctangent table. No dependencies.
`default_nettype none

package sh2bp_pkg;

  localparam int CORDIC_STAGES_DEF = 16;

  localparam int XIN_W  = 20;   // sensor-frame coordinate width
  localparam int TAG_W  = 16;
  localparam int REG_W  = 16;   // configuration register width
  localparam int BODY_W = 21;   // body-frame coordinate width
  localparam int BRG_W  = 16;
  localparam int RNG_W  = 21;

  localparam int FWD_W  = 21;   // radius plus forward coordinate
  localparam int PROD_W = 37;   // 21 x 16 signed product
  localparam int SUM_W  = 39;
  localparam int PT_W   = 24;   // rounded body point before saturation
  localparam int GUARD  = 8;
  localparam int XW     = 34;   // CORDIC x and y width
  localparam int ZW     = 25;   // CORDIC angle width, 2^-16 degree

  localparam int S_DATA_W = 56;
  localparam int M_DATA_W = 96;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] REG_MOUNT_COS   = 2'd0;
  localparam logic [1:0] REG_MOUNT_SIN   = 2'd1;
  localparam logic [1:0] REG_BODY_RADIUS = 2'd2;

  localparam logic signed [REG_W-1:0] MOUNT_COS_RST = 16'sd16384;

  localparam logic signed [ZW-1:0]     DEG90       = 25'sd5898240;
  localparam logic [23:0]              INV_GAIN    = 24'd10187902;
  localparam logic signed [BRG_W:0]    BEARING_LIM = 17'sd23040;
  localparam logic signed [PT_W-1:0]   BODY_MAX    = 24'sd1048575;
  localparam logic signed [PT_W-1:0]   BODY_MIN    = -24'sd1048576;
  localparam logic [25:0]              RANGE_MAX   = 26'd2097151;

  typedef struct packed {
    logic signed [XW-1:0]     x;
    logic signed [XW-1:0]     y;
    logic signed [ZW-1:0]     z;
    logic                     zero;
    logic signed [BODY_W-1:0] body_x;
    logic signed [BODY_W-1:0] body_y;
    logic [TAG_W-1:0]         tag;
  } cordic_item_t;

  // atan(2^-i) in 2^-16 degree.
  function automatic logic [ZW-1:0] atan_val(input int idx);
    logic [ZW-1:0] v;
    case (idx)
      0:  v = 25'd2949120;
      1:  v = 25'd1740967;
      2:  v = 25'd919879;
      3:  v = 25'd466945;
      4:  v = 25'd234379;
      5:  v = 25'd117304;
      6:  v = 25'd58666;
      7:  v = 25'd29335;
      8:  v = 25'd14668;
      9:  v = 25'd7334;
      10: v = 25'd3667;
      11: v = 25'd1833;
      12: v = 25'd917;
      13: v = 25'd458;
      14: v = 25'd229;
      15: v = 25'd115;
      16: v = 25'd57;
      17: v = 25'd29;
      18: v = 25'd14;
      19: v = 25'd7;
      20: v = 25'd4;
      21: v = 25'd2;
      22: v = 25'd1;
      default: v = 25'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ rtl/sh2bp_cordic_stage.sv @@
// One vectoring CORDIC iteration as a pipeline register stage.
// Depends on sh2bp_pkg for the item type and the arctangent table.
`default_nettype none

module sh2bp_cordic_stage #(
  parameter int STAGE_IDX = 0
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire sh2bp_pkg::cordic_item_t   in_item,
  output logic                           out_valid,
  output sh2bp_pkg::cordic_item_t        out_item
);
  import sh2bp_pkg::*;

  localparam logic signed [ZW-1:0] ATAN = atan_val(STAGE_IDX);

  logic signed [XW-1:0] x_sh;
  logic signed [XW-1:0] y_sh;
  cordic_item_t         item_next;

  assign x_sh = in_item.x >>> STAGE_IDX;
  assign y_sh = in_item.y >>> STAGE_IDX;

  always_comb begin
    item_next = in_item;
    // Rotate toward the x axis; y exactly zero counts as not positive.
    if (in_item.y > 0) begin
      item_next.x = in_item.x + y_sh;
      item_next.y = in_item.y - x_sh;
      item_next.z = in_item.z + ATAN;
    end else begin
      item_next.x = in_item.x - y_sh;
      item_next.y = in_item.y + x_sh;
      item_next.z = in_item.z - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/sensor_hit_to_body_polar_core.sv @@
// Top level of the sensor hit to body polar converter.
// Depends on sh2bp_pkg and sh2bp_cordic_stage.
//
// Usage:
//   Slave stream (s_tvalid, s_tready, s_tdata) carries one sensor hit per
//   transaction. Master stream (m_tvalid, m_tready, m_tdata) returns one
//   result per hit, in order. The hit is shifted by the body radius,
//   rotated by the mounting angle, then fed to a vectoring CORDIC for
//   bearing and range.
//   The pipeline has four front stages (capture, products, rounding,
//   saturation and pre-rotation), one stage per CORDIC iteration, and two
//   stages for the split gain multiply and the final output register.
//   Throughput is one transaction per cycle. Every stage has its own valid
//   bit and loads whenever it is empty or the stage after it moves, so a
//   stalled receiver only backs up the pipeline as it fills; bubbles are
//   squeezed out and s_tready stays high while any stage is empty.
//   Reset clears all valid bits and loads mount_cos = 16384, mount_sin = 0,
//   body_radius = 0. The user must write configuration (cfg_wen, cfg_index,
//   cfg_data) only while the pipeline is empty; the block never checks.
`default_nettype none

module sensor_hit_to_body_polar_core #(
  parameter int CORDIC_STAGES = sh2bp_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_wen,
  input  wire logic [sh2bp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sh2bp_pkg::REG_W-1:0]        cfg_data,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // x_forward[19:0], y_sideways[39:20], object_tag[55:40]
  input  wire logic [sh2bp_pkg::S_DATA_W-1:0]     s_tdata,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // body_x[20:0], body_y[41:21], bearing[57:42], range_out[78:58],
  // object_out[94:79], zero pad[95]
  output logic [sh2bp_pkg::M_DATA_W-1:0]          m_tdata
);
  import sh2bp_pkg::*;

  // Configuration registers.
  logic signed [REG_W-1:0] mount_cos;
  logic signed [REG_W-1:0] mount_sin;
  logic [REG_W-1:0]        body_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      mount_cos   <= MOUNT_COS_RST;
      mount_sin   <= '0;
      body_radius <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_MOUNT_COS:   mount_cos   <= cfg_data;
        REG_MOUNT_SIN:   mount_sin   <= cfg_data;
        REG_BODY_RADIUS: body_radius <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage enables form a backward chain from the output register.
  logic v1, v2, v3, v4, v5, v6;
  logic en1, en2, en3, en4, en5, en6;
  logic cvalid [0:CORDIC_STAGES];
  logic cen    [1:CORDIC_STAGES+1];
  cordic_item_t citem [0:CORDIC_STAGES];

  assign en6 = !v6 || m_tready;
  assign en5 = !v5 || en6;
  assign cen[CORDIC_STAGES+1] = en5;

  for (genvar k = 1; k <= CORDIC_STAGES; k++) begin : g_cen
    assign cen[k] = !cvalid[k] || cen[k+1];
  end

  assign en4 = !v4 || cen[1];
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign s_tready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (en1) v1 <= s_tvalid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= cvalid[CORDIC_STAGES];
      if (en6) v6 <= v5;
    end
  end

  // Stage 1: capture, add the body radius along the forward axis.
  logic signed [FWD_W-1:0]  fwd1;
  logic signed [XIN_W-1:0]  yp1;
  logic [TAG_W-1:0]         tag1;

  always_ff @(posedge clk) begin
    if (en1) begin
      fwd1 <= $signed({{(FWD_W-REG_W){1'b0}}, body_radius})
            + $signed({s_tdata[XIN_W-1], s_tdata[XIN_W-1:0]});
      yp1  <= s_tdata[2*XIN_W-1:XIN_W];
      tag1 <= s_tdata[2*XIN_W+TAG_W-1:2*XIN_W];
    end
  end

  // Stage 2: the four rotation products.
  logic signed [PROD_W-1:0] p_fc2, p_ys2, p_fs2, p_yc2;
  logic [TAG_W-1:0]         tag2;

  always_ff @(posedge clk) begin
    if (en2) begin
      p_fc2 <= fwd1 * mount_cos;
      p_ys2 <= yp1 * mount_sin;
      p_fs2 <= fwd1 * mount_sin;
      p_yc2 <= yp1 * mount_cos;
      tag2  <= tag1;
    end
  end

  // Stage 3: combine and round half up to the 2^-16 m grid.
  logic signed [SUM_W-1:0] sum_x, sum_y;
  logic signed [PT_W-1:0]  xe3, ye3;
  logic [TAG_W-1:0]        tag3;

  assign sum_x = SUM_W'(p_fc2) - SUM_W'(p_ys2) + SUM_W'(8192);
  assign sum_y = SUM_W'(p_fs2) + SUM_W'(p_yc2) + SUM_W'(8192);

  always_ff @(posedge clk) begin
    if (en3) begin
      xe3  <= sum_x[PT_W+13:14];
      ye3  <= sum_y[PT_W+13:14];
      tag3 <= tag2;
    end
  end

  // Stage 4: saturate the body point and turn the vector into the right
  // half plane for the CORDIC.
  cordic_item_t            item4, item4_next;
  logic signed [PT_W-1:0]  x0, y0;

  function automatic logic signed [BODY_W-1:0] sat_body(input logic signed [PT_W-1:0] v);
    logic signed [BODY_W-1:0] r;
    if (v > BODY_MAX) begin
      r = BODY_MAX[BODY_W-1:0];
    end else if (v < BODY_MIN) begin
      r = BODY_MIN[BODY_W-1:0];
    end else begin
      r = v[BODY_W-1:0];
    end
    return r;
  endfunction

  always_comb begin
    item4_next.z = '0;
    if (xe3 < 0 && ye3 >= 0) begin
      x0 = ye3;
      y0 = -xe3;
      item4_next.z = DEG90;
    end else if (xe3 < 0) begin
      x0 = -ye3;
      y0 = xe3;
      item4_next.z = -DEG90;
    end else begin
      x0 = xe3;
      y0 = ye3;
    end
    item4_next.x      = {{(XW-PT_W-GUARD){x0[PT_W-1]}}, x0, {GUARD{1'b0}}};
    item4_next.y      = {{(XW-PT_W-GUARD){y0[PT_W-1]}}, y0, {GUARD{1'b0}}};
    item4_next.zero   = (xe3 == '0) && (ye3 == '0);
    item4_next.body_x = sat_body(xe3);
    item4_next.body_y = sat_body(ye3);
    item4_next.tag    = tag3;
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      item4 <= item4_next;
    end
  end

  assign cvalid[0] = v4;
  assign citem[0]  = item4;

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    sh2bp_cordic_stage #(
      .STAGE_IDX (k)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (cen[k+1]),
      .in_valid  (cvalid[k]),
      .in_item   (citem[k]),
      .out_valid (cvalid[k+1]),
      .out_item  (citem[k+1])
    );
  end

  // Stage 5: gain correction split into two partial products, and bearing.
  cordic_item_t            cfin;
  logic [XW-2:0]           xpos;
  logic signed [ZW:0]      bsum;
  logic signed [BRG_W:0]   bq;
  logic signed [BRG_W-1:0] brg_next;
  logic [40:0]             p_lo5;
  logic [39:0]             p_hi5;
  logic signed [BRG_W-1:0] brg5;
  logic                    zero5;
  logic signed [BODY_W-1:0] bx5, by5;
  logic [TAG_W-1:0]        tag5;

  assign cfin = citem[CORDIC_STAGES];
  assign xpos = cfin.x[XW-1] ? '0 : cfin.x[XW-2:0];
  assign bsum = (ZW+1)'(256) - {cfin.z[ZW-1], cfin.z};
  assign bq   = bsum[ZW:9];

  always_comb begin
    if (cfin.zero) begin
      brg_next = '0;
    end else if (bq > BEARING_LIM) begin
      brg_next = BEARING_LIM[BRG_W-1:0];
    end else if (bq < -BEARING_LIM) begin
      brg_next = -BEARING_LIM[BRG_W-1:0];
    end else begin
      brg_next = bq[BRG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      p_lo5 <= {24'd0, xpos[16:0]} * {17'd0, INV_GAIN};
      p_hi5 <= {24'd0, xpos[XW-2:17]} * {16'd0, INV_GAIN};
      brg5  <= brg_next;
      zero5 <= cfin.zero;
      bx5   <= cfin.body_x;
      by5   <= cfin.body_y;
      tag5  <= cfin.tag;
    end
  end

  // Stage 6: sum the partial products, round and saturate the range.
  logic [57:0]      rtot;
  logic [25:0]      rq;
  logic [RNG_W-1:0] rng_next;
  logic [M_DATA_W-1:0] out_data;

  assign rtot = {1'b0, p_hi5, 17'd0} + {17'd0, p_lo5} + 58'h0_0000_8000_0000;
  assign rq   = rtot[57:32];

  always_comb begin
    if (zero5) begin
      rng_next = '0;
    end else if (rq > RANGE_MAX) begin
      rng_next = RANGE_MAX[RNG_W-1:0];
    end else begin
      rng_next = rq[RNG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      out_data <= {1'b0, tag5, rng_next, brg5, by5, bx5};
    end
  end

  assign m_tvalid = v6;
  assign m_tdata  = out_data;

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for sensor_hit_to_body_polar_core: a directed list of sensor hits and
// register writes, then random phases, each result checked against a local predictor.
// Depends on sh2bp_pkg and the converter RTL.

module tb_top;
  import sh2bp_pkg::*;

  localparam int STAGES         = CORDIC_STAGES_DEF;
  localparam int PIPE_LAT       = STAGES + 6;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 400;
  localparam int PHASES         = 10;
  localparam int PHASE_HITS     = 125;

  localparam longint QUARTER_TURN = 5898240;    // 90 degrees in 2^-16 degree
  localparam longint GAIN_INV_Q24 = 10187902;
  localparam longint HALF_Q32     = 64'sd2147483648;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // Field offsets inside m_tdata.
  localparam int OFF_BY  = BODY_W;
  localparam int OFF_BRG = 2 * BODY_W;
  localparam int OFF_RNG = OFF_BRG + BRG_W;
  localparam int OFF_OBJ = OFF_RNG + RNG_W;
  localparam int OFF_PAD = OFF_OBJ + TAG_W;

  typedef struct packed {
    logic signed [BODY_W-1:0] body_x;
    logic signed [BODY_W-1:0] body_y;
    logic signed [BRG_W-1:0]  bearing;
    logic [RNG_W-1:0]         range_out;
    logic [TAG_W-1:0]         object_out;
  } polar_result_t;

  typedef enum {ROW_HIT, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t               kind;
    logic [CFG_IDX_W-1:0]    reg_idx;
    logic [REG_W-1:0]        reg_val;
    logic signed [XIN_W-1:0] x_fwd;
    logic signed [XIN_W-1:0] y_side;
    logic [TAG_W-1:0]        tag;
    bit                      known;
    polar_result_t           want;
  } stim_row_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_wen   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [REG_W-1:0]      cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [M_DATA_W-1:0]   m_tdata;

  // Copy of the configuration registers as the block holds them.
  logic signed [REG_W-1:0] cos_q14    = MOUNT_COS_RST;
  logic signed [REG_W-1:0] sin_q14    = '0;
  logic [REG_W-1:0]        radius_u16 = '0;

  longint atan_step [0:23] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  polar_result_t due_results[$];
  int            errors      = 0;
  int            idle_cycles = 0;
  bit            sender_gaps = 1'b1;
  int            hold_asked  = 0;
  int            hold_served = 0;
  int            stall_left  = 0;
  int            calm_left   = 0;
  bit            rx_calm     = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sensor_hit_to_body_polar_core #(
    .CORDIC_STAGES(STAGES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Rotation into the body frame, then a vectoring CORDIC for bearing and range.
  function automatic polar_result_t predict_body_polar(input logic signed [XIN_W-1:0] xf,
                                                       input logic signed [XIN_W-1:0] ys,
                                                       input logic [TAG_W-1:0] tag);
    polar_result_t r;
    longint fwd, bx, by, cx, cy, cz, t, rng, brg;
    int i;
    fwd = longint'(radius_u16) + longint'(xf);
    bx  = (fwd * cos_q14 - longint'(ys) * sin_q14 + 8192) >>> 14;
    by  = (fwd * sin_q14 + longint'(ys) * cos_q14 + 8192) >>> 14;
    rng = 0;
    brg = 0;
    if (bx != 0 || by != 0) begin
      // Bring the vector into the right half plane first.
      if (bx < 0 && by >= 0) begin
        cx = by;
        cy = -bx;
        cz = QUARTER_TURN;
      end else if (bx < 0) begin
        cx = -by;
        cy = bx;
        cz = -QUARTER_TURN;
      end else begin
        cx = bx;
        cy = by;
        cz = 0;
      end
      cx = cx * 256;
      cy = cy * 256;
      for (i = 0; i < STAGES && i < 24; i++) begin
        t = cx;
        if (cy > 0) begin
          cx = cx + (cy >>> i);
          cy = cy - (t >>> i);
          cz = cz + atan_step[i];
        end else begin
          cx = cx - (cy >>> i);
          cy = cy + (t >>> i);
          cz = cz - atan_step[i];
        end
      end
      if (cx < 0) cx = 0;
      rng = (cx * GAIN_INV_Q24 + HALF_Q32) >>> 32;
      brg = (256 - cz) >>> 9;
    end
    if (brg > 23040) brg = 23040;
    if (brg < -23040) brg = -23040;
    if (rng > 2097151) rng = 2097151;
    if (bx > 1048575) bx = 1048575;
    if (bx < -1048576) bx = -1048576;
    if (by > 1048575) by = 1048575;
    if (by < -1048576) by = -1048576;
    r.body_x     = bx[BODY_W-1:0];
    r.body_y     = by[BODY_W-1:0];
    r.bearing    = brg[BRG_W-1:0];
    r.range_out  = rng[RNG_W-1:0];
    r.object_out = tag;
    return r;
  endfunction

  function automatic stim_row_t hit_row(input logic signed [XIN_W-1:0] xf,
                                        input logic signed [XIN_W-1:0] ys,
                                        input logic [TAG_W-1:0] tag);
    stim_row_t r;
    r.kind    = ROW_HIT;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.x_fwd   = xf;
    r.y_side  = ys;
    r.tag     = tag;
    r.known   = 1'b0;
    r.want    = '0;
    return r;
  endfunction

  // A hit that lands on the body origin: the point, bearing and range come out zero.
  function automatic stim_row_t origin_row(input logic signed [XIN_W-1:0] xf,
                                           input logic signed [XIN_W-1:0] ys,
                                           input logic [TAG_W-1:0] tag);
    stim_row_t r;
    r       = hit_row(xf, ys, tag);
    r.known = 1'b1;
    r.want.body_x     = 0;
    r.want.body_y     = 0;
    r.want.bearing    = 0;
    r.want.range_out  = 0;
    r.want.object_out = tag;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [REG_W-1:0] val);
    stim_row_t r;
    r         = hit_row(0, 0, 0);
    r.kind    = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic logic signed [XIN_W-1:0] pick_coord();
    logic signed [XIN_W-1:0] v;
    case ($urandom_range(0, 9))
      5, 6: v = XIN_W'($urandom_range(0, 2000) - 1000);
      7:    v = '0;
      8, 9: begin
        case ($urandom_range(0, 3))
          0:       v = {1'b1, {(XIN_W-1){1'b0}}};
          1:       v = {1'b0, {(XIN_W-1){1'b1}}};
          2:       v = '1;
          default: v = XIN_W'(1);
        endcase
      end
      default: v = XIN_W'($urandom);
    endcase
    return v;
  endfunction

  function automatic void check_field(input string name, input logic signed [63:0] want,
                                      input logic signed [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  task automatic send_hit(input logic signed [XIN_W-1:0] xf, input logic signed [XIN_W-1:0] ys,
                          input logic [TAG_W-1:0] tag, input bit known,
                          input polar_result_t want);
    s_tdata  <= {tag, ys, xf};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    due_results.push_back(known ? want : predict_body_polar(xf, ys, tag));
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3))
        @(posedge clk);
    end
  endtask

  // Stop sending and let the pipeline run empty.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (PIPE_LAT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_MOUNT_COS:   cos_q14    = val;
      REG_MOUNT_SIN:   sin_q14    = val;
      REG_BODY_RADIUS: radius_u16 = val;
      default: ;  // the spare index is ignored by the block
    endcase
  endtask

  task automatic set_mounting(input logic [REG_W-1:0] c, input logic [REG_W-1:0] s,
                              input logic [REG_W-1:0] radius);
    drain_results();
    write_reg(REG_MOUNT_COS, c);
    write_reg(REG_MOUNT_SIN, s);
    write_reg(REG_BODY_RADIUS, radius);
  endtask

  initial begin : stimulus
    stim_row_t rows[$];
    int ph, n;
    real ang;

    // Reset configuration: identity rotation, zero radius.
    rows.push_back(origin_row(0, 0, 16'h0000));
    rows.push_back(hit_row(20'sd524287, 20'sd524287, 16'hFFFF));
    rows.push_back(hit_row(-20'sd524288, -20'sd524288, 16'h0000));
    rows.push_back(hit_row(-20'sd524288, 0, 16'hA5A5));
    rows.push_back(hit_row(-20'sd1, 0, 16'h5A5A));
    rows.push_back(hit_row(0, 20'sd524287, 16'h0001));
    rows.push_back(hit_row(0, -20'sd524288, 16'h0002));
    rows.push_back(hit_row(20'sd1, 0, 16'h0003));
    rows.push_back(hit_row(0, -20'sd1, 16'h0004));
    rows.push_back(hit_row(20'sd524287, -20'sd524288, 16'h8000));
    rows.push_back(hit_row(-20'sd524288, 20'sd524287, 16'h7FFF));
    rows.push_back(hit_row(20'h55555, 20'hAAAAA, 16'h3C3C));
    // Out-of-range cosine with full radius drives the body point into saturation.
    rows.push_back(cfg_row(REG_MOUNT_COS, 16'h8000));
    rows.push_back(cfg_row(REG_MOUNT_SIN, 16'h7FFF));
    rows.push_back(cfg_row(REG_BODY_RADIUS, 16'hFFFF));
    rows.push_back(hit_row(20'sd524287, 20'sd524287, 16'h1111));
    rows.push_back(hit_row(-20'sd524288, -20'sd524288, 16'h2222));
    rows.push_back(hit_row(-20'sd524288, 20'sd524287, 16'h3333));
    rows.push_back(origin_row(-20'sd65535, 0, 16'h4444));
    // Sensor turned by 90 degrees.
    rows.push_back(cfg_row(REG_MOUNT_COS, 16'h0000));
    rows.push_back(cfg_row(REG_MOUNT_SIN, 16'h4000));
    rows.push_back(cfg_row(REG_BODY_RADIUS, 16'h0000));
    rows.push_back(hit_row(20'sd5, 0, 16'h0101));
    rows.push_back(hit_row(-20'sd7, 20'sd3, 16'h0202));
    rows.push_back(hit_row(0, -20'sd9, 16'h0303));
    // Both coefficients at minus one (0xC000).
    rows.push_back(cfg_row(REG_MOUNT_COS, 16'hC000));
    rows.push_back(cfg_row(REG_MOUNT_SIN, 16'hC000));
    rows.push_back(cfg_row(REG_BODY_RADIUS, 16'd1000));
    rows.push_back(hit_row(20'sd1, 20'sd1, 16'h0404));
    rows.push_back(origin_row(-20'sd1000, 0, 16'h0505));
    rows.push_back(cfg_row(REG_SPARE, 16'h1234));
    rows.push_back(hit_row(20'sd300, -20'sd200, 16'h0606));
    rows.push_back(hit_row(-20'sd524288, 0, 16'h0707));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        drain_results();
        write_reg(rows[i].reg_idx, rows[i].reg_val);
      end else begin
        send_hit(rows[i].x_fwd, rows[i].y_side, rows[i].tag, rows[i].known, rows[i].want);
      end
    end

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: set_mounting(16'h4000, 16'h0000, 16'h0000);
        1: set_mounting(16'hC000, 16'h0000, 16'hFFFF);
        2: set_mounting(16'h0000, 16'hC000, 16'hFFFF);
        3: set_mounting(REG_W'($urandom), REG_W'($urandom), REG_W'($urandom));
        default: begin
          ang = $urandom_range(0, 35999) * 3.14159265358979 / 18000.0;
          set_mounting(REG_W'(int'(16384.0 * $cos(ang))), REG_W'(int'(16384.0 * $sin(ang))),
                       REG_W'($urandom_range(0, 65535)));
        end
      endcase
      // One phase backs up the pipeline behind a long receiver stall.
      sender_gaps = (ph != 4 && ph != 7);
      if (ph == 4) hold_asked <= hold_asked + 1;
      for (n = 0; n < PHASE_HITS; n++) begin
        if ($urandom_range(0, 19) == 0)
          send_hit(XIN_W'(-int'(radius_u16)), '0, TAG_W'($urandom), 1'b0, '0);
        else
          send_hit(pick_coord(), pick_coord(), TAG_W'($urandom), 1'b0, '0);
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (calm_left == 0) begin
      rx_calm   <= ($urandom_range(0, 2) == 0);
      calm_left <= $urandom_range(100, 400);
    end else begin
      calm_left <= calm_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else if (hold_served != hold_asked) begin
      hold_served <= hold_served + 1;
      stall_left  <= LONG_HOLD;
      m_tready    <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    polar_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (due_results.size() == 0) begin
        $error("result transaction with no hit outstanding: m_tdata=%h", m_tdata);
        errors++;
      end else begin
        want = due_results.pop_front();
        check_field("body_x", want.body_x, $signed(m_tdata[0 +: BODY_W]));
        check_field("body_y", want.body_y, $signed(m_tdata[OFF_BY +: BODY_W]));
        check_field("bearing", want.bearing, $signed(m_tdata[OFF_BRG +: BRG_W]));
        check_field("range_out", want.range_out, m_tdata[OFF_RNG +: RNG_W]);
        check_field("object_out", want.object_out, m_tdata[OFF_OBJ +: TAG_W]);
        check_field("pad", 0, m_tdata[M_DATA_W-1:OFF_PAD]);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_wen || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
